FILE: rtl/core/dual_running_median_residual_macros.svh
// Assertion helpers for the running median block.
// DRMR_ASSERT checks outside reset, DRMR_ASSERT_ALWAYS also during reset.
`ifndef DUAL_RUNNING_MEDIAN_RESIDUAL_MACROS_SVH
`define DUAL_RUNNING_MEDIAN_RESIDUAL_MACROS_SVH
`ifndef SYNTH
`define DRMR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("drmr assertion failed");
`define DRMR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("drmr assertion failed");
`else
`define DRMR_ASSERT(lbl, clk, rst_n, prop)
`define DRMR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/drmr_pkg.sv
`timescale 1ns / 1ps
package drmr_pkg;

	localparam int SAMPLE_W       = 8;
	localparam int RES_W          = 9;
	localparam int LONG_HALF_DEF  = 24;
	localparam int SHORT_HALF_DEF = 14;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic signed [RES_W-1:0] residual_t;

	// broadcast to every cell of a sorted chain
	typedef struct packed {
		logic    en;
		logic    fill;
		sample_t leaving;
		sample_t entering;
	} slide_ctl_t;

	// handed from a cell to its right neighbor
	typedef struct packed {
		sample_t rem;  // value here once the leaving sample is removed
		logic    le;   // rem <= entering (always low in the last cell)
	} link_t;

endpackage

FILE: rtl/core/drmr_cell.sv
`timescale 1ns / 1ps
module drmr_cell #(
	parameter bit FIRST = 1'b0,
	parameter bit LAST  = 1'b0
) (
	input  logic                 clk,
	input  drmr_pkg::slide_ctl_t ctl,
	input  drmr_pkg::link_t      left,
	input  drmr_pkg::sample_t    right_val,
	output drmr_pkg::sample_t    val,
	output drmr_pkg::link_t      link,
	output drmr_pkg::sample_t    nxt
);

	drmr_pkg::sample_t val_q;
	drmr_pkg::sample_t rem;
	logic              del;
	logic              le;
	logic              prev_le;

	// sorted store: every cell at or past the leaving copy pulls from the right
	assign del = (val_q >= ctl.leaving);
	assign rem = del ? right_val : val_q;
	assign le  = LAST ? 1'b0 : (rem <= ctl.entering);
	assign prev_le = FIRST ? 1'b1 : left.le;

	// insert after all equal values
	always_comb begin
		priority if (le) begin
			nxt = rem;
		end else if (prev_le) begin
			nxt = ctl.entering;
		end else begin
			nxt = left.rem;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			val_q <= ctl.fill ? ctl.entering : nxt;
		end
	end

	assign val      = val_q;
	assign link.rem = rem;
	assign link.le  = le;

endmodule

FILE: rtl/core/drmr_chain.sv
`timescale 1ns / 1ps
module drmr_chain #(
	parameter int HALF = drmr_pkg::LONG_HALF_DEF
) (
	input  logic                 clk,
	input  drmr_pkg::slide_ctl_t ctl,
	output drmr_pkg::sample_t    median_nxt
);

	localparam int LEN = 2 * HALF + 1;

	drmr_pkg::sample_t vals  [LEN];
	drmr_pkg::sample_t nxts  [LEN];
	drmr_pkg::link_t   links [LEN];

	for (genvar i = 0; i < LEN; i++) begin : g_cell
		drmr_pkg::link_t   left_in;
		drmr_pkg::sample_t right_in;

		if (i == 0) begin : g_head
			assign left_in = '0;
		end else begin : g_body
			assign left_in = links[i-1];
		end

		if (i == LEN - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_mid
			assign right_in = vals[i+1];
		end

		drmr_cell #(
			.FIRST (i == 0),
			.LAST  (i == LEN - 1)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left      (left_in),
			.right_val (right_in),
			.val       (vals[i]),
			.link      (links[i]),
			.nxt       (nxts[i])
		);
	end

	assign median_nxt = ctl.fill ? ctl.entering : nxts[HALF];

endmodule

FILE: rtl/core/dual_running_median_residual.sv
// Dual running median with residual.
// Input channel: sample_valid / sample_ready with an 8-bit sample.
// Output channel: result_valid / result_ready; each transfer carries the long
// and short window results (valid flag, median, 9-bit signed residual of the
// centre sample minus the median). One result per input sample.
// The result is in the output register in the cycle after the input
// transfer. Throughput: one sample per cycle while the receiver takes each
// result; both sorted chains drop the oldest sample and insert the new one
// together, each cell deciding from its own value and its two neighbors.
// A window reports valid once it has seen HALF samples beyond the first;
// until then its median and residual read as zero. The first sample pads
// both windows and the history.
// Reset clears the sample count and the output valid flag; the next sample
// is treated as the first one.
// While the receiver stalls, the result is held and sample_ready stays low
// until the held result is taken (or is taken in the same cycle).
`timescale 1ns / 1ps
`include "dual_running_median_residual_macros.svh"
module dual_running_median_residual #(
	parameter int LONG_HALF  = drmr_pkg::LONG_HALF_DEF,
	parameter int SHORT_HALF = drmr_pkg::SHORT_HALF_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  drmr_pkg::sample_t     sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  long_valid,
	output drmr_pkg::sample_t     long_median,
	output drmr_pkg::residual_t   long_residual,
	output logic                  short_valid,
	output drmr_pkg::sample_t     short_median,
	output drmr_pkg::residual_t   short_residual
);

	localparam int LONG_WIN  = 2 * LONG_HALF + 1;
	localparam int SHORT_WIN = 2 * SHORT_HALF + 1;
	localparam int HIST_LEN  = (LONG_WIN > SHORT_WIN) ? LONG_WIN : SHORT_WIN;
	localparam int CNT_W     = $clog2(HIST_LEN + 1);

	drmr_pkg::sample_t   hist_q [HIST_LEN];
	logic [CNT_W-1:0]    seen_q;
	logic                result_valid_q;
	logic                long_valid_q;
	logic                short_valid_q;
	drmr_pkg::sample_t   long_median_q;
	drmr_pkg::sample_t   short_median_q;
	drmr_pkg::residual_t long_residual_q;
	drmr_pkg::residual_t short_residual_q;

	logic                 xfer;
	logic                 first;
	logic                 long_ok;
	logic                 short_ok;
	drmr_pkg::sample_t    long_centre;
	drmr_pkg::sample_t    short_centre;
	drmr_pkg::sample_t    long_med;
	drmr_pkg::sample_t    short_med;
	drmr_pkg::slide_ctl_t long_ctl;
	drmr_pkg::slide_ctl_t short_ctl;

	assign sample_ready = !result_valid_q || result_ready;
	assign xfer         = sample_valid && sample_ready;
	assign first        = (seen_q == '0);
	assign long_ok      = (seen_q >= CNT_W'(LONG_HALF));
	assign short_ok     = (seen_q >= CNT_W'(SHORT_HALF));

	// centre sample after this update
	assign long_centre  = first ? sample : hist_q[LONG_HALF-1];
	assign short_centre = first ? sample : hist_q[SHORT_HALF-1];

	assign long_ctl.en        = xfer;
	assign long_ctl.fill      = first;
	assign long_ctl.leaving   = hist_q[LONG_WIN-1];
	assign long_ctl.entering  = sample;
	assign short_ctl.en       = xfer;
	assign short_ctl.fill     = first;
	assign short_ctl.leaving  = hist_q[SHORT_WIN-1];
	assign short_ctl.entering = sample;

	drmr_chain #(.HALF(LONG_HALF)) u_long (
		.clk        (clk),
		.ctl        (long_ctl),
		.median_nxt (long_med)
	);

	drmr_chain #(.HALF(SHORT_HALF)) u_short (
		.clk        (clk),
		.ctl        (short_ctl),
		.median_nxt (short_med)
	);

	always_ff @(posedge clk) begin
		if (xfer) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				if (first || i == 0) begin
					hist_q[i] <= sample;
				end else begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (xfer && seen_q != CNT_W'(HIST_LEN)) begin
				seen_q <= seen_q + 1'b1;
			end
			if (xfer) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			long_valid_q    <= long_ok;
			short_valid_q   <= short_ok;
			long_median_q   <= long_ok ? long_med : '0;
			short_median_q  <= short_ok ? short_med : '0;
			long_residual_q <= long_ok
				? drmr_pkg::residual_t'({1'b0, long_centre} - {1'b0, long_med}) : '0;
			short_residual_q <= short_ok
				? drmr_pkg::residual_t'({1'b0, short_centre} - {1'b0, short_med}) : '0;
		end
	end

	assign result_valid   = result_valid_q;
	assign long_valid     = long_valid_q;
	assign short_valid    = short_valid_q;
	assign long_median    = long_median_q;
	assign short_median   = short_median_q;
	assign long_residual  = long_residual_q;
	assign short_residual = short_residual_q;

	`DRMR_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n |=> (!result_valid_q && seen_q == '0))
	`DRMR_ASSERT(a_seen_sat, clk, arst_n, seen_q <= CNT_W'(HIST_LEN))
	`DRMR_ASSERT(a_first_count, clk, arst_n, (xfer && first) |=> (seen_q == CNT_W'(1)))
	`DRMR_ASSERT(a_xfer_result, clk, arst_n, xfer |=> result_valid_q)
	`DRMR_ASSERT(a_long_zero, clk, arst_n,
		(result_valid_q && !long_valid_q) |-> (long_median_q == '0 && long_residual_q == '0))
	`DRMR_ASSERT(a_short_first, clk, arst_n,
		(result_valid_q && long_valid_q && SHORT_HALF <= LONG_HALF) |-> short_valid_q)

endmodule
